// File: rtl/vpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_pkg
// Shared types and constants of the vertex transform and projection block.
// ----------------------------------------------------------------------------
package vpp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd5;

    localparam int FOCAL_W  = 12;
    localparam int CENTER_W = 11;

    localparam logic [63:0]         ROW_X_RST    = 64'h0000_0000_0000_4000;
    localparam logic [63:0]         ROW_Y_RST    = 64'h0000_0000_4000_0000;
    localparam logic [63:0]         ROW_Z_RST    = 64'h0000_4000_0000_0000;
    localparam logic [FOCAL_W-1:0]  FOCAL_RST    = 12'd256;
    localparam logic [CENTER_W-1:0] CENTER_X_RST = 11'd320;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 11'd240;

    // depth = round(2^38 / T), T with 22 fraction bits
    localparam int                 DEPTH_NUM_W = 40;
    localparam logic [39:0]        DEPTH_NUM   = 40'h80_0000_0000;
    localparam int                 DEPTH_W     = 20;
    localparam int                 DEPTH_QB    = 21;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 20'hFFFFF;

    // fraction bits appended to the projection numerator before division
    localparam int PROJ_FRAC = 5;

    typedef struct packed {
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic [31:0] color;
        logic        strip_end;
    } t_sideband;

    typedef struct packed {
        logic behind;
        logic neg_x;
        logic neg_y;
    } t_flags;

endpackage

// File: rtl/vpp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_in_if
// Vertex input channel: valid/ready with one vertex per beat.
// ----------------------------------------------------------------------------
interface vpp_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic        [15:0]           tex_u;
    logic        [15:0]           tex_v;
    logic        [31:0]           color;
    logic                         strip_end;

    modport source (
        output valid, pos_x, pos_y, pos_z, tex_u, tex_v, color, strip_end,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, tex_u, tex_v, color, strip_end,
        output ready
    );
endinterface

// File: rtl/vpp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_out_if
// Projected vertex output channel: valid/ready with one vertex per beat.
// ----------------------------------------------------------------------------
interface vpp_out_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] screen_x;
    logic signed [COORD_BITS-1:0] screen_y;
    logic        [19:0]           depth;
    logic        [15:0]           out_u;
    logic        [15:0]           out_v;
    logic        [31:0]           out_color;
    logic                         last_of_strip;
    logic                         behind;

    modport source (
        output valid, screen_x, screen_y, depth, out_u, out_v, out_color,
               last_of_strip, behind,
        input  ready
    );
    modport sink (
        input  valid, screen_x, screen_y, depth, out_u, out_v, out_color,
               last_of_strip, behind,
        output ready
    );
endinterface

// File: rtl/vpp_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_xform
// Two-stage affine transform: nine products, then three row sums.
// ----------------------------------------------------------------------------
module vpp_xform #(
    parameter int CB = 16,
    parameter int TW = 34
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CB-1:0] i_x,
    input  logic signed [CB-1:0] i_y,
    input  logic signed [CB-1:0] i_z,
    input  logic        [63:0]   i_row_x,
    input  logic        [63:0]   i_row_y,
    input  logic        [63:0]   i_row_z,
    output logic signed [TW-1:0] o_t0,
    output logic signed [TW-1:0] o_t1,
    output logic signed [TW-1:0] o_t2
);
    localparam int PW = CB + 16;

    logic        [63:0]   w_row [0:2];
    logic signed [PW-1:0] r_prod [0:2][0:2];
    logic signed [15:0]   r_tr [0:2];
    logic signed [TW-1:0] r_t [0:2];

    assign w_row[0] = i_row_x;
    assign w_row[1] = i_row_y;
    assign w_row[2] = i_row_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[r][0] <= $signed(w_row[r][15:0])  * i_x;
                r_prod[r][1] <= $signed(w_row[r][31:16]) * i_y;
                r_prod[r][2] <= $signed(w_row[r][47:32]) * i_z;
                r_tr[r]      <= $signed(w_row[r][63:48]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_t[r] <= TW'(r_prod[r][0]) + TW'(r_prod[r][1]) + TW'(r_prod[r][2])
                        + (TW'(r_tr[r]) <<< 14);
            end
        end
    end

    assign o_t0 = r_t[0];
    assign o_t1 = r_t[1];
    assign o_t2 = r_t[2];
endmodule

// File: rtl/vpp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag when the quotient does not fit in QB bits.
// ----------------------------------------------------------------------------
module vpp_div #(
    parameter int NW = 51,
    parameter int DW = 33,
    parameter int QB = 21
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo,
    output logic          o_ovf
);
    localparam int RW = DW + QB;
    localparam int CW = ((NW > RW) ? NW : RW) + 1;

    logic [RW-1:0] r_rem [0:QB];
    logic [DW-1:0] r_den [0:QB];
    logic [QB-1:0] r_quo [0:QB];
    logic          r_ovf [0:QB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= CW'(i_num) >= (CW'(i_den) << QB);
            r_rem[0] <= RW'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_stage
        localparam int K = QB - s;
        logic [RW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = RW'(r_den[s-1]) << K;
        assign w_ge = r_rem[s-1] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? (r_rem[s-1] - w_sh) : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_ovf[s] <= r_ovf[s-1];
                r_quo[s] <= r_quo[s-1] | (QB'(w_ge) << K);
            end
        end
    end

    assign o_quo = r_quo[QB];
    assign o_ovf = r_ovf[QB];
endmodule

// File: rtl/vertex_perspective_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_perspective_project
// Affine vertex transform followed by perspective projection and 1/z depth.
//
//   channel   dir  handshake            payload
//   i_in      in   valid/ready          pos_x/y/z, tex_u/v, color, strip_end
//   o_out     out  valid/ready          screen_x/y, depth, u/v, color, flags
//   i_cfg_*   in   write enable only    register index, 64-bit data
//
// One vertex per clock sustained while the output is not stalled. QB =
// max(COORD_BITS+3, 21) is the divider quotient width, one bit per stage.
// Reset is synchronous, clears the valid bits and resets the configuration
// registers. All stages advance together when the output stage is empty or
// taken, so a stall freezes the whole pipe and the last stage holds its beat.
// ----------------------------------------------------------------------------
module vertex_perspective_project #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    vpp_in_if.sink                              i_in,
    vpp_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [vpp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [vpp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int CB  = COORD_BITS;
    localparam int TW  = CB + 18;
    localparam int DW  = TW - 1;
    localparam int NXW = TW + vpp_pkg::FOCAL_W;
    localparam int NPW = NXW + vpp_pkg::PROJ_FRAC;
    localparam int QB  = (CB + 3 > vpp_pkg::DEPTH_QB) ? CB + 3 : vpp_pkg::DEPTH_QB;
    localparam int FW  = QB + 2;
    localparam int LAT = QB + 5;

    localparam logic signed [FW-1:0] SAT_HI = FW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [FW-1:0] SAT_LO = -SAT_HI - FW'(1);

    // configuration
    logic [63:0]                     r_row_x, r_row_y, r_row_z;
    logic [vpp_pkg::FOCAL_W-1:0]     r_focal;
    logic [vpp_pkg::CENTER_W-1:0]    r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= vpp_pkg::ROW_X_RST;
            r_row_y <= vpp_pkg::ROW_Y_RST;
            r_row_z <= vpp_pkg::ROW_Z_RST;
            r_focal <= vpp_pkg::FOCAL_RST;
            r_cx    <= vpp_pkg::CENTER_X_RST;
            r_cy    <= vpp_pkg::CENTER_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vpp_pkg::CFG_ROW_X:    r_row_x <= i_cfg_data;
                vpp_pkg::CFG_ROW_Y:    r_row_y <= i_cfg_data;
                vpp_pkg::CFG_ROW_Z:    r_row_z <= i_cfg_data;
                vpp_pkg::CFG_FOCAL:    r_focal <= i_cfg_data[vpp_pkg::FOCAL_W-1:0];
                vpp_pkg::CFG_CENTER_X: r_cx    <= i_cfg_data[vpp_pkg::CENTER_W-1:0];
                vpp_pkg::CFG_CENTER_Y: r_cy    <= i_cfg_data[vpp_pkg::CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic                 w_en;
    logic [LAT-1:0]       r_vld;
    vpp_pkg::t_sideband   r_sb  [0:LAT-1];
    vpp_pkg::t_flags      r_flg [2:LAT-2];
    vpp_pkg::t_flags      n_flg;

    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0] <= '{tex_u: i_in.tex_u, tex_v: i_in.tex_v,
                         color: i_in.color, strip_end: i_in.strip_end};
            for (int s = 1; s < LAT; s++) begin
                r_sb[s] <= r_sb[s-1];
            end
            r_flg[2] <= n_flg;
            for (int s = 3; s <= LAT - 2; s++) begin
                r_flg[s] <= r_flg[s-1];
            end
        end
    end

    // transform
    logic signed [TW-1:0] w_t0, w_t1, w_t2;

    vpp_xform #(.CB(CB), .TW(TW)) u_xform (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (i_in.pos_x),
        .i_y     (i_in.pos_y),
        .i_z     (i_in.pos_z),
        .i_row_x (r_row_x),
        .i_row_y (r_row_y),
        .i_row_z (r_row_z),
        .o_t0    (w_t0),
        .o_t1    (w_t1),
        .o_t2    (w_t2)
    );

    // magnitudes scaled by focal length
    logic [TW-1:0]  w_mag_x, w_mag_y;
    logic [NXW-1:0] r_nx, r_ny;
    logic [DW-1:0]  r_den;

    assign n_flg.behind = w_t2[TW-1] || (w_t2 == '0);
    assign n_flg.neg_x  = w_t0[TW-1];
    // y axis is flipped, so a positive t1 lands on the negative side
    assign n_flg.neg_y  = !w_t1[TW-1] && (w_t1 != '0);
    assign w_mag_x      = w_t0[TW-1] ? TW'(-w_t0) : TW'(w_t0);
    assign w_mag_y      = w_t1[TW-1] ? TW'(-w_t1) : TW'(w_t1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx  <= NXW'(w_mag_x) * NXW'(r_focal);
            r_ny  <= NXW'(w_mag_y) * NXW'(r_focal);
            r_den <= n_flg.behind ? DW'(1) : w_t2[DW-1:0];
        end
    end

    // dividers
    logic [QB-1:0] w_qx, w_qy, w_qd;
    logic          w_ox, w_oy, w_od;

    vpp_div #(.NW(NPW), .DW(DW), .QB(QB)) u_div_x (
        .i_clk (i_clk), .i_en (w_en),
        .i_num ({r_nx, {vpp_pkg::PROJ_FRAC{1'b0}}}), .i_den (r_den),
        .o_quo (w_qx), .o_ovf (w_ox)
    );

    vpp_div #(.NW(NPW), .DW(DW), .QB(QB)) u_div_y (
        .i_clk (i_clk), .i_en (w_en),
        .i_num ({r_ny, {vpp_pkg::PROJ_FRAC{1'b0}}}), .i_den (r_den),
        .o_quo (w_qy), .o_ovf (w_oy)
    );

    vpp_div #(.NW(vpp_pkg::DEPTH_NUM_W), .DW(DW), .QB(QB)) u_div_d (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (vpp_pkg::DEPTH_NUM), .i_den (r_den),
        .o_quo (w_qd), .o_ovf (w_od)
    );

    // rounding, centering and saturation
    logic [QB:0]                 w_qx1, w_qy1;
    logic [QB-1:0]               w_mx, w_my;
    logic signed [FW-1:0]        w_vx, w_vy, w_cxs, w_cys;
    logic [vpp_pkg::DEPTH_QB-1:0] w_qd1;
    logic                        w_dsat;
    vpp_pkg::t_flags             w_flg;

    assign w_flg  = r_flg[LAT-2];
    assign w_qx1  = {1'b0, w_qx} + (QB+1)'(1);
    assign w_qy1  = {1'b0, w_qy} + (QB+1)'(1);
    // overflow stands in for a magnitude far past any saturation limit
    assign w_mx   = w_ox ? {1'b1, {(QB-1){1'b0}}} : w_qx1[QB:1];
    assign w_my   = w_oy ? {1'b1, {(QB-1){1'b0}}} : w_qy1[QB:1];
    assign w_cxs  = $signed(FW'({r_cx, 4'b0000}));
    assign w_cys  = $signed(FW'({r_cy, 4'b0000}));
    assign w_vx   = (w_flg.neg_x ? -$signed(FW'(w_mx)) : $signed(FW'(w_mx))) + w_cxs;
    assign w_vy   = (w_flg.neg_y ? -$signed(FW'(w_my)) : $signed(FW'(w_my))) + w_cys;
    assign w_dsat = w_od || (w_qd >= QB'({vpp_pkg::DEPTH_QB{1'b1}}));
    assign w_qd1  = w_qd[vpp_pkg::DEPTH_QB-1:0] + vpp_pkg::DEPTH_QB'(1);

    logic signed [CB-1:0]          r_sx, r_sy;
    logic [vpp_pkg::DEPTH_W-1:0]   r_dep;
    logic                          r_behind;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_behind <= w_flg.behind;
            if (w_flg.behind) begin
                r_sx  <= '0;
                r_sy  <= '0;
                r_dep <= '0;
            end else begin
                r_sx  <= (w_vx > SAT_HI) ? CB'(SAT_HI) :
                         (w_vx < SAT_LO) ? CB'(SAT_LO) : w_vx[CB-1:0];
                r_sy  <= (w_vy > SAT_HI) ? CB'(SAT_HI) :
                         (w_vy < SAT_LO) ? CB'(SAT_LO) : w_vy[CB-1:0];
                r_dep <= w_dsat ? vpp_pkg::DEPTH_MAX : w_qd1[vpp_pkg::DEPTH_QB-1:1];
            end
        end
    end

    assign o_out.valid         = r_vld[LAT-1];
    assign o_out.screen_x      = r_sx;
    assign o_out.screen_y      = r_sy;
    assign o_out.depth         = r_dep;
    assign o_out.out_u         = r_sb[LAT-1].tex_u;
    assign o_out.out_v         = r_sb[LAT-1].tex_v;
    assign o_out.out_color     = r_sb[LAT-1].color;
    assign o_out.last_of_strip = r_sb[LAT-1].strip_end;
    assign o_out.behind        = r_behind;

    // behind-the-viewer beats carry zeroed coordinates
    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.behind |->
            o_out.screen_x == '0 && o_out.screen_y == '0 && o_out.depth == '0)
        else $error("behind beat with nonzero coordinates");

    // a visible vertex always has a nonzero reciprocal depth
    a_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.behind |-> o_out.depth != '0)
        else $error("visible beat with zero depth");

    // the pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");

    // an accepted vertex enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted vertex lost at entry");
endmodule
